// ===== rtl/fdes_pkg.sv =====
package fdes_pkg;

   // Field widths
   localparam int NAME_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int HALF_W    = 16;
   localparam int CLUSTER_W = 32;
   localparam int SIZE_W    = 32;
   localparam int SECTOR_W  = 32;
   localparam int COUNT_W   = 24;
   localparam int LFN_W     = 6;
   localparam int KIND_W    = 2;
   localparam int SPC_W     = 8;
   localparam int RSV_W     = 16;
   localparam int COPIES_W  = 8;
   localparam int FATSZ_W   = 32;
   localparam int ROOT_W    = 32;
   localparam int ENTRIES_W = 17;

   // Stream word widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 128;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPC      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RESERVED = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COPIES   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAT_SIZE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROOT     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENTRIES  = 3'd5;

   // Register reset values
   localparam logic [SPC_W-1:0]     SPC_RST      = 8'd8;
   localparam logic [RSV_W-1:0]     RESERVED_RST = 16'd32;
   localparam logic [COPIES_W-1:0]  COPIES_RST   = 8'd2;
   localparam logic [FATSZ_W-1:0]   FAT_SIZE_RST = 32'd0;
   localparam logic [ROOT_W-1:0]    ROOT_RST     = 32'd2;
   localparam logic [ENTRIES_W-1:0] ENTRIES_RST  = 17'd0;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUBDIR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DIR_END = 2'd3;

   // Directory entry codes
   localparam logic [NAME_W-1:0]    NAME_END     = 8'h00;
   localparam logic [NAME_W-1:0]    NAME_DELETED = 8'hE5;
   localparam logic [ATTR_W-1:0]    ATTR_LFN     = 8'h0F;
   localparam logic [CLUSTER_W-1:0] EOC_A        = 32'h0FFF_FFFF;
   localparam logic [CLUSTER_W-1:0] EOC_B        = 32'h0FFF_FFF8;
   localparam logic [SIZE_W-1:0]    SIZE_ONES    = 32'hFFFF_FFFF;
   localparam logic [SIZE_W-1:0]    SECTOR_ROUND = 32'd511;
   localparam int                   SECTOR_SHIFT = 9;
   localparam logic [LFN_W-1:0]     LFN_MAX      = 6'd63;

   // Visited bitmap layout: rows of 16 cluster bits
   localparam int ROW_W   = 16;
   localparam int ROW_SEL = 4;

   localparam int MAX_CLUSTERS_DEF = 65536;

   // Decoded entry, carried from accept into the lookup stage
   typedef struct packed {
      logic                 dir_end;
      logic                 sub_cand;
      logic                 deleted;
      logic [CLUSTER_W-1:0] cluster;
      logic [CLUSTER_W-1:0] rel_cluster;
      logic [COUNT_W-1:0]   sec_count;
      logic [LFN_W-1:0]     lfn;
      logic [SIZE_W-1:0]    size;
   } dec_type;

   // Bitmap control from the pipeline
   typedef struct packed {
      logic lookup;
      logic commit;
   } vis_ctl_type;

endpackage

// ===== rtl/fdes_ram.sv =====
module fdes_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fdes_decode.sv =====
module fdes_decode
   import fdes_pkg::*;
#(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [NAME_W-1:0]    name_first,
   input  logic [ATTR_W-1:0]    attr_byte,
   input  logic [HALF_W-1:0]    cluster_high,
   input  logic [HALF_W-1:0]    cluster_low,
   input  logic [SIZE_W-1:0]    entry_size,
   input  logic                 last_in_cluster,
   input  logic [ENTRIES_W-1:0] fat_entries,
   input  logic [ROOT_W-1:0]    root_cluster,
   output dec_type              dec
);

   logic [LFN_W-1:0] run_len_ff, run_len_in;
   logic             dir_ended_ff, dir_ended_in;

   logic [CLUSTER_W-1:0] clus_raw;
   logic [CLUSTER_W-1:0] clus;
   logic [SIZE_W-1:0]    size_rnd;
   logic                 size_marker;
   logic                 run_zero;
   logic                 active;
   logic                 end_mark;
   logic                 proc;
   logic                 is_lfn;
   logic                 in_range;

   // Start cluster, end-of-chain marks read as zero
   always_comb begin
      clus_raw = {cluster_high, cluster_low};
      clus     = (clus_raw == EOC_A || clus_raw == EOC_B) ? '0 : clus_raw;
   end

   // Entry classification against the run state
   always_comb begin
      size_marker = (entry_size == '0) || (entry_size == SIZE_ONES);
      run_zero    = (run_len_ff == '0);
      active      = !dir_ended_ff;
      end_mark    = active && run_zero && (name_first == NAME_END);
      proc        = active && !end_mark;
      is_lfn      = (attr_byte == ATTR_LFN);
      in_range    = (clus != '0) && (clus < {{(CLUSTER_W-ENTRIES_W){1'b0}}, fat_entries})
                    && (clus < CLUSTER_W'(MAX_CLUSTERS));
      size_rnd    = entry_size + SECTOR_ROUND;

      dec.dir_end     = end_mark;
      dec.sub_cand    = proc && run_zero && size_marker && in_range;
      dec.deleted     = proc && !is_lfn && (name_first == NAME_DELETED) && !size_marker;
      dec.cluster     = clus;
      dec.rel_cluster = clus - root_cluster;
      dec.sec_count   = COUNT_W'(size_rnd[SIZE_W-1:SECTOR_SHIFT]);
      dec.lfn         = active ? run_len_ff : '0;
      dec.size        = entry_size;
   end

   // Run length and end-of-directory state
   always_comb begin
      run_len_in   = run_len_ff;
      dir_ended_in = dir_ended_ff;
      if (accept) begin
         if (last_in_cluster) begin
            run_len_in   = '0;
            dir_ended_in = 1'b0;
         end else if (end_mark) begin
            dir_ended_in = 1'b1;
         end else if (proc) begin
            if (is_lfn) begin
               run_len_in = (run_len_ff == LFN_MAX) ? run_len_ff : run_len_ff + 1'b1;
            end else begin
               run_len_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff   <= '0;
         dir_ended_ff <= 1'b0;
      end else begin
         run_len_ff   <= run_len_in;
         dir_ended_ff <= dir_ended_in;
      end
   end

endmodule

// ===== rtl/fdes_visit.sv =====
module fdes_visit
   import fdes_pkg::*;
#(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vis_ctl_type          ctl,
   input  logic [CLUSTER_W-1:0] cluster,
   output logic                 seen,
   output logic                 busy
);

   localparam int DEPTH  = (MAX_CLUSTERS + ROW_W - 1) / ROW_W;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic              busy_ff, busy_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   // Row and bit of the entry now in the lookup stage
   logic [ADDR_W-1:0]  s1_addr_ff, s1_addr_in;
   logic [ROW_SEL-1:0] s1_bit_ff, s1_bit_in;

   // Most recent write, for read-during-write
   logic              fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff, fwd_addr_in;
   logic [ROW_W-1:0]  fwd_data_ff, fwd_data_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ROW_W-1:0]  wr_data;
   logic [ROW_W-1:0]  rd_data;
   logic [ROW_W-1:0]  row_cur;

   fdes_ram #(
      .WIDTH  (ROW_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.lookup),
      .rd_addr (cluster[ROW_SEL +: ADDR_W]),
      .rd_data (rd_data)
   );

   // Current row content and test-and-set write
   always_comb begin
      row_cur = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data;
      seen    = row_cur[s1_bit_ff];
      if (busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = ctl.commit && !seen;
         wr_addr = s1_addr_ff;
         wr_data = row_cur | (ROW_W'(1) << s1_bit_ff);
      end
   end

   // Clearing sweep, lookup capture, write tracking
   always_comb begin
      busy_in    = busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
      s1_addr_in = ctl.lookup ? cluster[ROW_SEL +: ADDR_W] : s1_addr_ff;
      s1_bit_in  = ctl.lookup ? cluster[ROW_SEL-1:0] : s1_bit_ff;
      fwd_valid_in = fwd_valid_ff || wr_en;
      fwd_addr_in  = wr_en ? wr_addr : fwd_addr_ff;
      fwd_data_in  = wr_en ? wr_data : fwd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         clr_cnt_ff   <= clr_cnt_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      s1_bit_ff   <= s1_bit_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/fat_dir_entry_deleted_scanner_top.sv =====
// An accepted word passes the stage 1 register (bitmap lookup) and the output register.
// Throughput: one word per cycle unless rsp stalls; the visited bitmap is a one-read
// one-write RAM with forwarding from the last write, so consecutive entries on the same
// row do not stall. Reset (synchronous): clears run state, output valid and configuration
// to defaults, then clears the bitmap one 16-bit row per cycle with req_tready low.
module fat_dir_entry_deleted_scanner_top
   import fdes_pkg::*;
#(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // name_first[7:0], attr_byte[15:8], cluster_high[31:16], cluster_low[47:32],
   // entry_size[79:48]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cluster_out[31:0], start_sector[63:32], sector_count[87:64], extent_valid[88],
   // long_name_entries[94:89], file_size[126:95], zero[127]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // kind[1:0]
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [SPC_W-1:0]     spc_ff, spc_in;
   logic [RSV_W-1:0]     rsv_ff, rsv_in;
   logic [COPIES_W-1:0]  copies_ff, copies_in;
   logic [FATSZ_W-1:0]   fat_size_ff, fat_size_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [ENTRIES_W-1:0] entries_ff, entries_in;
   logic [SECTOR_W-1:0]  base_ff, base_in;

   // Pipeline
   logic        accept;
   logic        s1_adv;
   logic        s1_valid_ff, s1_valid_in;
   dec_type     s1_dec_ff, s1_dec_in;
   dec_type     dec;
   vis_ctl_type vis_ctl;
   logic        seen;
   logic        busy;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;

   logic [KIND_W-1:0]    kind;
   logic                 ext_valid;
   logic [SECTOR_W-1:0]  sec_prod;
   logic [SECTOR_W-1:0]  start_sec;
   logic [CLUSTER_W-1:0] clus_out;
   logic [COUNT_W-1:0]   cnt_out;
   logic [SIZE_W-1:0]    size_out;

   // Handshakes
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;

   // Config write decode
   always_comb begin
      spc_in      = spc_ff;
      rsv_in      = rsv_ff;
      copies_in   = copies_ff;
      fat_size_in = fat_size_ff;
      root_in     = root_ff;
      entries_in  = entries_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_SPC:      spc_in      = csr_wdata[SPC_W-1:0];
            CSR_RESERVED: rsv_in      = csr_wdata[RSV_W-1:0];
            CSR_COPIES:   copies_in   = csr_wdata[COPIES_W-1:0];
            CSR_FAT_SIZE: fat_size_in = csr_wdata[FATSZ_W-1:0];
            CSR_ROOT:     root_in     = csr_wdata[ROOT_W-1:0];
            CSR_ENTRIES:  entries_in  = csr_wdata[ENTRIES_W-1:0];
            default: ;
         endcase
      end
      // Data area base: FAT copies plus reserved sectors, mod 2^32
      base_in = SECTOR_W'(fat_size_ff * SECTOR_W'(copies_ff))
                + SECTOR_W'(rsv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff      <= SPC_RST;
         rsv_ff      <= RESERVED_RST;
         copies_ff   <= COPIES_RST;
         fat_size_ff <= FAT_SIZE_RST;
         root_ff     <= ROOT_RST;
         entries_ff  <= ENTRIES_RST;
      end else begin
         spc_ff      <= spc_in;
         rsv_ff      <= rsv_in;
         copies_ff   <= copies_in;
         fat_size_ff <= fat_size_in;
         root_ff     <= root_in;
         entries_ff  <= entries_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   fdes_decode #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_decode (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .name_first      (req_tdata[7:0]),
      .attr_byte       (req_tdata[15:8]),
      .cluster_high    (req_tdata[31:16]),
      .cluster_low     (req_tdata[47:32]),
      .entry_size      (req_tdata[79:48]),
      .last_in_cluster (req_tlast),
      .fat_entries     (entries_ff),
      .root_cluster    (root_ff),
      .dec             (dec)
   );

   // Bitmap lookup at accept, test-and-set when the entry leaves stage 1
   always_comb begin
      vis_ctl.lookup = accept;
      vis_ctl.commit = s1_adv && s1_dec_ff.sub_cand;
   end

   fdes_visit #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_visit (
      .clock   (clock),
      .reset   (reset),
      .ctl     (vis_ctl),
      .cluster (dec.cluster),
      .seen    (seen),
      .busy    (busy)
   );

   // Stage 1 register
   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_dec_in   = accept ? dec : s1_dec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dec_ff <= s1_dec_in;
   end

   // Result assembly
   always_comb begin
      if (s1_dec_ff.dir_end) begin
         kind = KIND_DIR_END;
      end else if (s1_dec_ff.deleted) begin
         kind = KIND_DELETED;
      end else if (s1_dec_ff.sub_cand && !seen) begin
         kind = KIND_SUBDIR;
      end else begin
         kind = KIND_NONE;
      end
      ext_valid = s1_dec_ff.deleted && (s1_dec_ff.cluster != '0);
      sec_prod  = SECTOR_W'(s1_dec_ff.rel_cluster * SECTOR_W'(spc_ff));
      start_sec = ext_valid ? sec_prod + base_ff : '0;
      clus_out  = (kind == KIND_SUBDIR || kind == KIND_DELETED) ? s1_dec_ff.cluster : '0;
      cnt_out   = ext_valid ? s1_dec_ff.sec_count : '0;
      size_out  = s1_dec_ff.deleted ? s1_dec_ff.size : '0;

      rsp_data_in  = s1_adv ? {1'b0, size_out, s1_dec_ff.lfn, ext_valid, cnt_out,
                               start_sec, clus_out} : rsp_data_ff;
      rsp_kind_in  = s1_adv ? kind : rsp_kind_ff;
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule
